// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL modules of the utilization price block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge outside reset.
`define ASSERT_CLK(name, clk_i, rst_i, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (rst_i) (prop)) else $error(msg);

// Check that a condition implies a property in the same cycle.
`define ASSERT_IMPLY(name, clk_i, rst_i, cond, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (rst_i) (cond) |-> (prop)) else $error(msg);

`endif

// ===== hw/rtl/wupm_pkg.sv =====
// Shared widths, constants, register map and types of the utilization price block.
package wupm_pkg;

  // Field widths
  localparam int GAS_W    = 48;
  localparam int UTIL_W   = 10;
  localparam int MULT_W   = 14;
  localparam int TARGET_W = 7;
  localparam int ADJUST_W = 10;
  localparam int MAXM_W   = 7;

  // Default window depth
  localparam int WINDOW_DEFAULT = 64;

  // Register reset values
  localparam logic [GAS_W-1:0]    LIMIT_RESET  = 48'd30000000;
  localparam logic [TARGET_W-1:0] TARGET_RESET = 7'd50;
  localparam logic [ADJUST_W-1:0] ADJUST_RESET = 10'd10;
  localparam logic [MAXM_W-1:0]   MAXM_RESET   = 7'd10;

  // Arithmetic constants
  localparam logic [UTIL_W-1:0] UTIL_CAP  = 10'd1000;
  localparam logic [MULT_W-1:0] BASE_PCT  = 14'd100;
  localparam logic [MAXM_W-1:0] MAXM_CAP  = 7'd100;
  localparam logic [MAXM_W-1:0] MAXM_MIN  = 7'd1;
  // avg * 100 fits in the gas width plus seven bits
  localparam int UTIL_DVD_W = GAS_W + 7;

  // Divide by 100 through a reciprocal: floor(x * RECIP >> RECIP_SHIFT)
  localparam int PROD_W      = UTIL_W + ADJUST_W;
  localparam int RECIP_W     = 21;
  localparam int RECIP_SHIFT = 27;
  localparam logic [RECIP_W-1:0] RECIP = 21'd1342178;

  // Configuration port
  localparam int DATA_W = 64;
  localparam int ADDR_W = 5;
  localparam int IDX_LSB = 3;
  localparam logic [1:0] REG_LIMIT  = 2'd0;
  localparam logic [1:0] REG_TARGET = 2'd1;
  localparam logic [1:0] REG_ADJUST = 2'd2;
  localparam logic [1:0] REG_MAXM   = 2'd3;

  // Divider status seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// ===== hw/rtl/wupm_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by both divisions.
module wupm_div #(
  parameter int DVD_W = wupm_pkg::UTIL_DVD_W,
  parameter int DVS_W = wupm_pkg::GAS_W
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [DVD_W-1:0]          dividend,
  input  logic [DVS_W-1:0]          divisor,
  output logic [DVD_W-1:0]          quotient,
  output wupm_pkg::div_status_t     status
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] dq;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;
  logic             done;

  logic [DVS_W:0]   shifted;
  logic [DVS_W+1:0] trial;
  logic             fits;

  // Trial subtract of the divisor from the shifted remainder
  assign shifted = {rem, dq[DVD_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dvs};
  assign fits    = ~trial[DVS_W+1];

  // Control: iteration count and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (start) begin
      cnt  <= CNT_W'(DVD_W);
      done <= 1'b0;
    end else if (cnt != '0) begin
      cnt  <= cnt - 1'b1;
      done <= (cnt == CNT_W'(1));
    end else begin
      done <= 1'b0;
    end
  end

  // Datapath: shift in one quotient bit per step
  always_ff @(posedge clk) begin
    if (start) begin
      dq  <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (cnt != '0) begin
      dq  <= {dq[DVD_W-2:0], fits};
      rem <= fits ? trial[DVS_W-1:0] : shifted[DVS_W-1:0];
    end
  end

  assign quotient    = dq;
  assign status.busy = (cnt != '0);
  assign status.done = done;

endmodule

// ===== hw/rtl/wupm_window.sv =====
// Sliding window of recent gas words with running sum and fill count.
`include "assert_macros.svh"

module wupm_window #(
  parameter int WINDOW_BLOCKS = wupm_pkg::WINDOW_DEFAULT,
  parameter int CNT_W = $clog2(WINDOW_BLOCKS + 1),
  parameter int SUM_W = wupm_pkg::GAS_W + CNT_W
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       upd,
  input  logic [wupm_pkg::GAS_W-1:0] gas,
  output logic [SUM_W-1:0]           sum,
  output logic [CNT_W-1:0]           count
);

  localparam int SLOT_W = (WINDOW_BLOCKS > 1) ? $clog2(WINDOW_BLOCKS) : 1;

  logic [wupm_pkg::GAS_W-1:0] mem [WINDOW_BLOCKS];
  logic [wupm_pkg::GAS_W-1:0] old;
  logic [SLOT_W-1:0]          slot;
  logic                       full;

  assign full = (count == CNT_W'(WINDOW_BLOCKS));

  // Store: read the oldest word at the write slot, write the new word there
  always_ff @(posedge clk) begin
    old <= mem[slot];
    if (upd) begin
      mem[slot] <= gas;
    end
  end

  // Advance slot, count and running sum
  always_ff @(posedge clk) begin
    if (rst) begin
      slot  <= '0;
      count <= '0;
      sum   <= '0;
    end else if (upd) begin
      slot <= (slot == SLOT_W'(WINDOW_BLOCKS - 1)) ? '0 : slot + 1'b1;
      if (full) begin
        sum <= sum - SUM_W'(old) + SUM_W'(gas);
      end else begin
        count <= count + 1'b1;
        sum   <= sum + SUM_W'(gas);
      end
    end
  end

  `ASSERT_CLK(a_count_max, clk, rst, count <= CNT_W'(WINDOW_BLOCKS), "fill count above depth")
  `ASSERT_IMPLY(a_empty_sum, clk, rst, count == '0, sum == '0, "empty window with nonzero sum")

endmodule

// ===== hw/rtl/window_utilization_price_multiplier_top.sv =====
// Top level: config registers, sequencer and price stages of the utilization block.
//
// Usage: each word on the input channel (block_gas, in_valid/in_ready) is the
// gas used by one finished block. It enters a window of the last WINDOW_BLOCKS
// words; the block answers with one word on the output channel
// (avg_utilization, multiplier_pct, out_valid/out_ready).
// Configuration goes through the APB port: block_gas_limit at 0x00,
// target_percent at 0x08, adjust_percent at 0x10, max_multiplier at 0x18.
// Each word passes through the shared restoring divider, which runs one
// quotient bit per cycle, once for the window average and once for the
// percent of limit.
// in_ready is high only while the sequencer is idle, so one word is in work
// at a time; the next word is taken only after the last one has passed the
// finish state and the sequencer is back in idle.
// A finished result sits in the output register; the next word may be taken
// while it waits. If the receiver stalls, the next result holds in its last
// stage until the output register frees.
// Reset (rst, synchronous) empties the window, clears the sum and count and
// loads the register defaults; no clearing pass is needed.
`include "assert_macros.svh"

module window_utilization_price_multiplier_top #(
  parameter int WINDOW_BLOCKS = wupm_pkg::WINDOW_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  // Input channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [wupm_pkg::GAS_W-1:0]        block_gas,
  // Output channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [wupm_pkg::UTIL_W-1:0]       avg_utilization,
  output logic [wupm_pkg::MULT_W-1:0]       multiplier_pct,
  // Configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [wupm_pkg::ADDR_W-1:0]       paddr,
  input  logic [wupm_pkg::DATA_W-1:0]       pwdata,
  output logic [wupm_pkg::DATA_W-1:0]       prdata,
  output logic                              pready
);

  localparam int GAS_W  = wupm_pkg::GAS_W;
  localparam int UTIL_W = wupm_pkg::UTIL_W;
  localparam int MULT_W = wupm_pkg::MULT_W;
  localparam int CNT_W  = $clog2(WINDOW_BLOCKS + 1);
  localparam int SUM_W  = GAS_W + CNT_W;
  localparam int DIV_W  = (SUM_W > wupm_pkg::UTIL_DVD_W) ? SUM_W : wupm_pkg::UTIL_DVD_W;
  localparam int PROD_W = wupm_pkg::PROD_W;
  localparam int FULL_W = PROD_W + wupm_pkg::RECIP_W;

  // Sequencer states
  localparam logic [3:0] ST_IDLE       = 4'd0;
  localparam logic [3:0] ST_UPDATE     = 4'd1;
  localparam logic [3:0] ST_AVG_START  = 4'd2;
  localparam logic [3:0] ST_AVG_WAIT   = 4'd3;
  localparam logic [3:0] ST_UTIL_START = 4'd4;
  localparam logic [3:0] ST_UTIL_WAIT  = 4'd5;
  localparam logic [3:0] ST_SCALE      = 4'd6;
  localparam logic [3:0] ST_RECIP      = 4'd7;
  localparam logic [3:0] ST_FINISH     = 4'd8;

  // Configuration registers
  logic [GAS_W-1:0]              block_gas_limit;
  logic [wupm_pkg::TARGET_W-1:0] target_percent;
  logic [wupm_pkg::ADJUST_W-1:0] adjust_percent;
  logic [wupm_pkg::MAXM_W-1:0]   max_multiplier;
  logic                          cfg_wr;
  logic [1:0]                    cfg_idx;

  // Sequencer and datapath registers
  logic [3:0]        state;
  logic [3:0]        state_next;
  logic [GAS_W-1:0]  gas;
  logic [GAS_W-1:0]  avg;
  logic [UTIL_W-1:0] util;
  logic              above;
  logic [PROD_W-1:0] prod;
  logic [MULT_W-1:0] scaled;

  // Window and divider connections
  logic [SUM_W-1:0]            sum;
  logic [CNT_W-1:0]            count;
  logic                        div_start;
  logic [DIV_W-1:0]            div_dvd;
  logic [GAS_W-1:0]            div_dvs;
  logic [DIV_W-1:0]            div_quo;
  wupm_pkg::div_status_t       div_st;

  // Combinational helpers
  logic [DIV_W-1:0]              avg_x100;
  logic [UTIL_W-1:0]             util_sat;
  logic [UTIL_W-1:0]             diff;
  logic [FULL_W-1:0]             recip_full;
  logic [wupm_pkg::MAXM_W-1:0]   maxm_clamped;
  logic [MULT_W-1:0]             cap;
  logic [MULT_W-1:0]             raised;
  logic [MULT_W-1:0]             mult_final;
  logic                          out_free;

  // Configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = paddr[wupm_pkg::IDX_LSB +: 2];

  always_ff @(posedge clk) begin
    if (rst) begin
      block_gas_limit <= wupm_pkg::LIMIT_RESET;
      target_percent  <= wupm_pkg::TARGET_RESET;
      adjust_percent  <= wupm_pkg::ADJUST_RESET;
      max_multiplier  <= wupm_pkg::MAXM_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        wupm_pkg::REG_LIMIT:  block_gas_limit <= pwdata[GAS_W-1:0];
        wupm_pkg::REG_TARGET: target_percent  <= pwdata[wupm_pkg::TARGET_W-1:0];
        wupm_pkg::REG_ADJUST: adjust_percent  <= pwdata[wupm_pkg::ADJUST_W-1:0];
        wupm_pkg::REG_MAXM:   max_multiplier  <= pwdata[wupm_pkg::MAXM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      wupm_pkg::REG_LIMIT:  prdata = wupm_pkg::DATA_W'(block_gas_limit);
      wupm_pkg::REG_TARGET: prdata = wupm_pkg::DATA_W'(target_percent);
      wupm_pkg::REG_ADJUST: prdata = wupm_pkg::DATA_W'(adjust_percent);
      wupm_pkg::REG_MAXM:   prdata = wupm_pkg::DATA_W'(max_multiplier);
      default:              prdata = '0;
    endcase
  end

  // Window store, sum and count
  wupm_window #(
    .WINDOW_BLOCKS(WINDOW_BLOCKS),
    .CNT_W(CNT_W),
    .SUM_W(SUM_W)
  ) u_window (
    .clk  (clk),
    .rst  (rst),
    .upd  (state == ST_UPDATE),
    .gas  (gas),
    .sum  (sum),
    .count(count)
  );

  // Shared divider: window average first, then percent of limit
  assign avg_x100 = (DIV_W'(avg) << 6) + (DIV_W'(avg) << 5) + (DIV_W'(avg) << 2);
  assign div_start = (state == ST_AVG_START) || (state == ST_UTIL_START);
  assign div_dvd   = (state == ST_AVG_START) ? DIV_W'(sum) : avg_x100;
  assign div_dvs   = (state == ST_AVG_START) ? GAS_W'(count) : block_gas_limit;

  wupm_div #(
    .DVD_W(DIV_W),
    .DVS_W(GAS_W)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(div_dvd),
    .divisor (div_dvs),
    .quotient(div_quo),
    .status  (div_st)
  );

  // Saturate the utilization, zero for a zero limit
  always_comb begin
    if (block_gas_limit == '0) begin
      util_sat = '0;
    end else if (div_quo > DIV_W'(wupm_pkg::UTIL_CAP)) begin
      util_sat = wupm_pkg::UTIL_CAP;
    end else begin
      util_sat = div_quo[UTIL_W-1:0];
    end
  end

  // Price stages: excess times adjust, divide by 100, add to the base, clamp to ceiling; base alone at or below target
  assign diff       = util - UTIL_W'(target_percent);
  assign recip_full = FULL_W'(prod) * FULL_W'(wupm_pkg::RECIP);

  always_comb begin
    if (max_multiplier < wupm_pkg::MAXM_MIN) begin
      maxm_clamped = wupm_pkg::MAXM_MIN;
    end else if (max_multiplier > wupm_pkg::MAXM_CAP) begin
      maxm_clamped = wupm_pkg::MAXM_CAP;
    end else begin
      maxm_clamped = max_multiplier;
    end
  end

  assign cap        = MULT_W'(maxm_clamped) * wupm_pkg::BASE_PCT;
  assign raised     = wupm_pkg::BASE_PCT + scaled;
  assign mult_final = !above ? wupm_pkg::BASE_PCT : ((raised < cap) ? raised : cap);
  assign out_free   = !out_valid || out_ready;

  // Sequencer next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:       if (in_valid) state_next = ST_UPDATE;
      ST_UPDATE:     state_next = ST_AVG_START;
      ST_AVG_START:  state_next = ST_AVG_WAIT;
      ST_AVG_WAIT:   if (div_st.done) state_next = ST_UTIL_START;
      ST_UTIL_START: state_next = ST_UTIL_WAIT;
      ST_UTIL_WAIT:  if (div_st.done) state_next = ST_SCALE;
      ST_SCALE:      state_next = ST_RECIP;
      ST_RECIP:      state_next = ST_FINISH;
      ST_FINISH:     if (out_free) state_next = ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == ST_IDLE);

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      gas <= block_gas;
    end
    if ((state == ST_AVG_WAIT) && div_st.done) begin
      avg <= div_quo[GAS_W-1:0];
    end
    if ((state == ST_UTIL_WAIT) && div_st.done) begin
      util <= util_sat;
    end
    if (state == ST_SCALE) begin
      above <= (util > UTIL_W'(target_percent));
      prod  <= PROD_W'(diff) * PROD_W'(adjust_percent);
    end
    if (state == ST_RECIP) begin
      scaled <= recip_full[wupm_pkg::RECIP_SHIFT +: MULT_W];
    end
  end

  // Output register: load on finish, drop on take
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_FINISH) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_FINISH) && out_free) begin
      avg_utilization <= util;
      multiplier_pct  <= mult_final;
    end
  end

  `ASSERT_IMPLY(a_util_range, clk, rst, out_valid,
    avg_utilization <= wupm_pkg::UTIL_CAP, "utilization above cap")
  `ASSERT_IMPLY(a_mult_range, clk, rst, out_valid,
    multiplier_pct >= 14'd100 && multiplier_pct <= 14'd10000, "multiplier out of range")
  `ASSERT_IMPLY(a_div_done_wait, clk, rst, div_st.done,
    state == ST_AVG_WAIT || state == ST_UTIL_WAIT, "divider done outside a wait state")
  `ASSERT_IMPLY(a_div_idle_start, clk, rst, div_start, !div_st.busy, "divider started while busy")

endmodule
